[hdl/bia_pkg.sv]
// Shared constants, opcodes and controller/datapath interface types for the ID allocator.
package bia_pkg;

	localparam int MAX_IDS   = 512;
	localparam int WORD_W    = 64;
	localparam int NUM_WORDS = MAX_IDS / WORD_W;
	localparam int WADDR_W   = $clog2(NUM_WORDS);
	localparam int BIT_W     = $clog2(WORD_W);
	localparam int ID_W      = 10;
	localparam int GRANT_W   = 9;
	localparam int OP_W      = 2;

	localparam logic [ID_W-1:0] LIMIT_RESET = ID_W'(MAX_IDS);

	localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
	localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
	localparam logic [OP_W-1:0] OP_LIMIT = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_SCAN,
		ST_FREE,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic load;
		logic start;
		logic scan_next;
		logic commit_alloc;
		logic commit_free;
		logic commit_limit;
		logic set_ok;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic is_alloc;
		logic is_free;
		logic is_limit;
		logic free_ok;
		logic lim_ge;
		logic hit;
		logic last;
		logic out_free;
	} dp_stat_t;

endpackage

[hdl/bia_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module bia_ram #(
	parameter int Width = 64,
	parameter int Depth = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);

	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[hdl/bia_dp.sv]
// Datapath: request registers, bitmap memory, word scan logic, limit and result registers.
module bia_dp
	import bia_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  dp_cmd_t             cmd,
	output dp_stat_t            stat,
	input  logic [OP_W-1:0]     opcode,
	input  logic [ID_W-1:0]     release_id,
	input  logic [ID_W-1:0]     requested_limit,
	input  logic                out_ready,
	output logic                out_valid,
	output logic [GRANT_W-1:0]  granted_id,
	output logic                status,
	output logic [ID_W-1:0]     current_limit
);

	logic [OP_W-1:0]      op_q;
	logic [ID_W-1:0]      rid_q;
	logic [ID_W-1:0]      req_q;
	logic [WADDR_W-1:0]   ptr_q;
	logic [ID_W-1:0]      id_limit_q;
	logic [NUM_WORDS-1:0] rowv_q;
	logic [GRANT_W-1:0]   grant_q;
	logic                 fail_q;
	logic                 out_valid_q;
	logic [GRANT_W-1:0]   out_grant_q;
	logic                 out_fail_q;
	logic [ID_W-1:0]      out_limit_q;

	logic [WADDR_W-1:0]   start_w;
	logic [WADDR_W-1:0]   raddr;
	logic [WORD_W-1:0]    rdata;
	logic [WORD_W-1:0]    word;
	logic [ID_W-1:0]      base;
	logic [ID_W-1:0]      lim_off;
	logic [WADDR_W:0]     ptr_nxt;
	logic [ID_W-1:0]      next_base;
	logic [WORD_W-1:0]    hi_mask;
	logic [WORD_W-1:0]    lo_mask;
	logic [WORD_W-1:0]    cand;
	logic [WORD_W-1:0]    busy;
	logic [BIT_W-1:0]     idx;
	logic [WORD_W-1:0]    alloc_bit;
	logic [WORD_W-1:0]    free_bit;
	logic                 we;
	logic [WORD_W-1:0]    wdata;

	always_comb begin
		case (op_q)
			OP_FREE:  start_w = rid_q[BIT_W+WADDR_W-1:BIT_W];
			OP_LIMIT: start_w = req_q[BIT_W+WADDR_W-1:BIT_W];
			default:  start_w = '0;
		endcase
	end

	assign raddr = cmd.scan_next ? WADDR_W'(ptr_q + 1'b1) : start_w;

	bia_ram #(
		.Width(WORD_W),
		.Depth(NUM_WORDS)
	) u_map (
		.clk  (clk),
		.we   (we),
		.waddr(ptr_q),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	// A row never written still holds its reset contents: only ID 0 is in use.
	assign word = rowv_q[ptr_q] ? rdata :
		((ptr_q == '0) ? WORD_W'(1) : '0);

	assign base      = {{(ID_W-WADDR_W-BIT_W){1'b0}}, ptr_q, {BIT_W{1'b0}}};
	assign lim_off   = id_limit_q - base;
	assign ptr_nxt   = {1'b0, ptr_q} + 1'b1;
	assign next_base = ID_W'({ptr_nxt, {BIT_W{1'b0}}});

	assign hi_mask = (lim_off >= ID_W'(WORD_W)) ? '1 : ~({WORD_W{1'b1}} << lim_off[BIT_W-1:0]);
	assign lo_mask = (ptr_q == req_q[BIT_W+WADDR_W-1:BIT_W]) ?
		({WORD_W{1'b1}} << req_q[BIT_W-1:0]) : '1;

	assign cand = ~word & hi_mask;
	assign busy = word & hi_mask & lo_mask;

	always_comb begin
		idx = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (cand[i]) begin
				idx = BIT_W'(i);
			end
		end
	end

	assign alloc_bit = WORD_W'(1) << idx;
	assign free_bit  = WORD_W'(1) << rid_q[BIT_W-1:0];
	assign we        = cmd.commit_alloc | cmd.commit_free;
	assign wdata     = cmd.commit_alloc ? (word | alloc_bit) : (word & ~free_bit);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= opcode;
			rid_q <= release_id;
			req_q <= requested_limit;
		end
		if (cmd.start || cmd.scan_next) begin
			ptr_q <= raddr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			id_limit_q  <= LIMIT_RESET;
			rowv_q      <= '0;
			grant_q     <= '0;
			fail_q      <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				grant_q <= '0;
				fail_q  <= 1'b1;
			end
			if (cmd.commit_alloc) begin
				grant_q <= {ptr_q, idx};
			end
			if (cmd.commit_alloc || cmd.commit_free || cmd.commit_limit || cmd.set_ok) begin
				fail_q <= 1'b0;
			end
			if (we) begin
				rowv_q[ptr_q] <= 1'b1;
			end
			if (cmd.commit_limit) begin
				id_limit_q <= req_q;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_grant_q <= grant_q;
			out_fail_q  <= fail_q;
			out_limit_q <= id_limit_q;
		end
	end

	assign stat.is_alloc = (op_q == OP_ALLOC);
	assign stat.is_free  = (op_q == OP_FREE);
	assign stat.is_limit = (op_q == OP_LIMIT);
	assign stat.free_ok  = (rid_q != '0) && (rid_q < id_limit_q);
	assign stat.lim_ge   = (req_q >= id_limit_q);
	assign stat.hit      = (op_q == OP_ALLOC) ? (|cand) : (|busy);
	assign stat.last     = (next_base >= id_limit_q);
	assign stat.out_free = !out_valid_q || out_ready;

	assign out_valid     = out_valid_q;
	assign granted_id    = out_grant_q;
	assign status        = out_fail_q;
	assign current_limit = out_limit_q;

endmodule

[hdl/bia_ctrl.sv]
// Controller state machine: sequences dispatch, word scan, bitmap update and response.
module bia_ctrl
	import bia_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				if (stat.is_alloc || (stat.is_limit && !stat.lim_ge)) begin
					state_d = ST_SCAN;
				end else if (stat.is_free && stat.free_ok) begin
					state_d = ST_FREE;
				end else begin
					state_d = ST_RESP;
				end
			end
			ST_SCAN: begin
				if (stat.hit || stat.last) begin
					state_d = ST_RESP;
				end
			end
			ST_FREE: state_d = ST_RESP;
			ST_RESP: begin
				if (stat.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_DISPATCH: begin
				cmd.start  = stat.is_alloc || (stat.is_limit && !stat.lim_ge) ||
					(stat.is_free && stat.free_ok);
				cmd.set_ok = stat.is_limit && stat.lim_ge;
			end
			ST_SCAN: begin
				if (stat.is_alloc) begin
					cmd.commit_alloc = stat.hit;
				end else begin
					cmd.commit_limit = !stat.hit && stat.last;
				end
				cmd.scan_next = !stat.hit && !stat.last;
			end
			ST_FREE: cmd.commit_free = 1'b1;
			ST_RESP: cmd.out_load = stat.out_free;
			default: ;
		endcase
	end

endmodule

[hdl/bitmap_id_allocator.sv]
// Top level of the bitmap identifier allocator: controller, datapath and checks.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-----------------------------------------
//   request | in        | in_valid / in_ready  | opcode, release_id, requested_limit
//   result  | out       | out_valid / out_ready| granted_id, status, current_limit
//
// One request is in work at a time. An allocation or a limit below the current one
// passes through dispatch, a scan of 64-bit map words (1 to 8) and response; a free
// through dispatch, update and response. A rejected free, a limit at or above the
// current one and an undefined opcode go from dispatch to response. The scan reads
// one map word per cycle from the single read port of the bitmap memory.
// Reset leaves the map with only ID 0 in use and the limit at 512, with no
// clearing pass. A stalled result stays in its output register; the next request
// is still accepted and runs, and only waits to deliver its own result.
module bitmap_id_allocator
	import bia_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [OP_W-1:0]    opcode,
	input  logic [ID_W-1:0]    release_id,
	input  logic [ID_W-1:0]    requested_limit,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [GRANT_W-1:0] granted_id,
	output logic               status,
	output logic [ID_W-1:0]    current_limit
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	bia_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.stat    (stat),
		.cmd     (cmd)
	);

	bia_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.opcode         (opcode),
		.release_id     (release_id),
		.requested_limit(requested_limit),
		.out_ready      (out_ready),
		.out_valid      (out_valid),
		.granted_id     (granted_id),
		.status         (status),
		.current_limit  (current_limit)
	);

`ifndef SYNTHESIS
	// The controller never takes a second beat right after accepting one.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("request accepted while previous one still in work");

	// A granted ID is never the reserved ID 0, and a nonzero grant is a success.
	a_grant_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && granted_id != '0) |-> (status == 1'b0))
		else $error("nonzero grant reported with refusal status");

	// The limit lies between 1 and MAX_IDS.
	a_limit_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (current_limit != '0 && current_limit <= LIMIT_RESET))
		else $error("reported limit out of range");

	// A scan only starts or advances while a request is in work.
	a_scan_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.start || cmd.scan_next) |-> !in_ready)
		else $error("map scan active while idle");
`endif

endmodule
